>>> src/l4tp_pkg.sv
// ----------------------------------------------------------------------------
// l4tp_pkg: shared types and constants of the L2/L3/L4 tuple parser
// Result codes, kinds, header constants and the per-frame summary struct.
// ----------------------------------------------------------------------------
package l4tp_pkg;

    localparam int unsigned ADDR_WORDS = 8;
    localparam int unsigned WIDX_W     = $clog2(ADDR_WORDS);

    localparam logic [15:0] ET_IPV4 = 16'h0800;
    localparam logic [15:0] ET_IPV6 = 16'h86DD;
    localparam logic [15:0] ET_ARP  = 16'h0806;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    localparam logic [7:0] ETH_HDR_LEN   = 8'd14;
    localparam logic [5:0] IPV6_HDR_LEN  = 6'd40;
    localparam logic [8:0] IPV4_MIN_LEN  = 9'd20;
    localparam logic [8:0] TCP_MIN_LEN   = 9'd20;
    localparam logic [8:0] UDP_ICMP_LEN  = 9'd8;
    localparam logic [3:0] VERSION_IPV4  = 4'd4;
    localparam logic [3:0] VERSION_IPV6  = 4'd6;

    // byte offsets of fields within the frame
    localparam logic [7:0] OFF_V4_PROTO = 8'd23;
    localparam logic [7:0] OFF_V4_ADDR  = 8'd26;
    localparam logic [7:0] END_V4_ADDR  = 8'd34;
    localparam logic [7:0] OFF_V6_NXT   = 8'd20;
    localparam logic [7:0] OFF_V6_ADDR  = 8'd22;
    localparam logic [7:0] END_V6_ADDR  = 8'd54;
    localparam logic [7:0] OFF_SRC_MAC  = 8'd6;
    localparam logic [7:0] OFF_MAC_END  = 8'd12;
    localparam logic [7:0] OFF_MAX      = 8'd255;

    typedef enum logic [3:0] {
        ST_OK           = 4'd0,
        ST_NOT_IP       = 4'd1,
        ST_SHORT_ETH    = 4'd2,
        ST_SHORT_VER    = 4'd3,
        ST_V6_MISMATCH  = 4'd4,
        ST_V4_MISMATCH  = 4'd5,
        ST_SHORT_V4     = 4'd6,
        ST_SHORT_V4_OPT = 4'd7,
        ST_SHORT_V6     = 4'd8,
        ST_SHORT_UDP    = 4'd9,
        ST_SHORT_ICMP   = 4'd10
    } t_status;

    typedef enum logic [1:0] {
        L3_OTHER = 2'd0,
        L3_IPV4  = 2'd1,
        L3_IPV6  = 2'd2,
        L3_ARP   = 2'd3
    } t_l3_kind;

    typedef enum logic [1:0] {
        L4_NONE = 2'd0,
        L4_TCP  = 2'd1,
        L4_UDP  = 2'd2,
        L4_ICMP = 2'd3
    } t_l4_kind;

    typedef logic [ADDR_WORDS-1:0][31:0] t_addr_words;

    typedef struct packed {
        t_status     status;
        t_l3_kind    l3_kind;
        t_l4_kind    l4_kind;
        logic [5:0]  hdr_len;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic [WIDX_W-1:0] last_idx;
    } t_summary;

endpackage

>>> src/l4tp_capture.sv
// ----------------------------------------------------------------------------
// l4tp_capture: per-byte header capture and end-of-frame checks
// Updates offset-selected capture registers on every accepted byte and, on
// the last byte, gives the frame summary and address words.
// ----------------------------------------------------------------------------
module l4tp_capture (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [15:0]           i_ether_type,
    input  logic [7:0]            i_frame_byte,
    input  logic                  i_last_byte,
    output l4tp_pkg::t_summary    o_summary,
    output l4tp_pkg::t_addr_words o_words
);

    logic [7:0]            r_off,   n_off;
    logic [15:0]           r_et,    n_et;
    logic [47:0]           r_dmac,  n_dmac;
    logic [47:0]           r_smac,  n_smac;
    logic [3:0]            r_ver,   n_ver;
    logic [5:0]            r_hl,    n_hl;
    logic [7:0]            r_proto, n_proto;
    l4tp_pkg::t_addr_words r_addr,  n_addr;
    logic [15:0]           r_sport, n_sport;
    logic [15:0]           r_dport, n_dport;

    logic [7:0] w_v4_aoff;
    logic [7:0] w_v6_aoff;
    logic [7:0] w_l4_start;
    logic [7:0] w_rel;
    logic [8:0] w_len;
    logic [8:0] w_l4_start9;

    assign w_v4_aoff   = r_off - l4tp_pkg::OFF_V4_ADDR;
    assign w_v6_aoff   = r_off - l4tp_pkg::OFF_V6_ADDR;
    assign w_l4_start  = l4tp_pkg::ETH_HDR_LEN + {2'b00, n_hl};
    assign w_rel       = r_off - w_l4_start;
    assign w_len       = {1'b0, r_off} + 9'd1;
    assign w_l4_start9 = {1'b0, w_l4_start};

    // capture update for the byte at the current offset
    always_comb begin
        n_et    = r_et;
        n_dmac  = r_dmac;
        n_smac  = r_smac;
        n_ver   = r_ver;
        n_hl    = r_hl;
        n_proto = r_proto;
        n_addr  = r_addr;
        n_sport = r_sport;
        n_dport = r_dport;
        n_off   = r_off;
        if (i_accept) begin
            if (r_off == 8'd0) begin
                n_et = i_ether_type;
            end
            if (r_off < l4tp_pkg::OFF_SRC_MAC) begin
                n_dmac = {r_dmac[39:0], i_frame_byte};
            end else if (r_off < l4tp_pkg::OFF_MAC_END) begin
                n_smac = {r_smac[39:0], i_frame_byte};
            end
            if (r_off == l4tp_pkg::ETH_HDR_LEN) begin
                n_ver = i_frame_byte[7:4];
                n_hl  = (n_et == l4tp_pkg::ET_IPV6) ? l4tp_pkg::IPV6_HDR_LEN
                                                    : {i_frame_byte[3:0], 2'b00};
            end
            if (n_et == l4tp_pkg::ET_IPV4) begin
                if (r_off == l4tp_pkg::OFF_V4_PROTO) begin
                    n_proto = i_frame_byte;
                end
                if (r_off >= l4tp_pkg::OFF_V4_ADDR && r_off < l4tp_pkg::END_V4_ADDR) begin
                    n_addr[w_v4_aoff[4:2]] = {r_addr[w_v4_aoff[4:2]][23:0], i_frame_byte};
                end
            end else if (n_et == l4tp_pkg::ET_IPV6) begin
                if (r_off == l4tp_pkg::OFF_V6_NXT) begin
                    n_proto = i_frame_byte;
                end
                if (r_off >= l4tp_pkg::OFF_V6_ADDR && r_off < l4tp_pkg::END_V6_ADDR) begin
                    n_addr[w_v6_aoff[4:2]] = {r_addr[w_v6_aoff[4:2]][23:0], i_frame_byte};
                end
            end
            // ports sit at the l4 start, which may overlap a short ipv4 header
            if (r_off >= w_l4_start) begin
                if (w_rel < 8'd2) begin
                    n_sport = {r_sport[7:0], i_frame_byte};
                end else if (w_rel < 8'd4) begin
                    n_dport = {r_dport[7:0], i_frame_byte};
                end
            end
            n_off = (r_off < l4tp_pkg::OFF_MAX) ? r_off + 8'd1 : l4tp_pkg::OFF_MAX;
        end
    end

    // end-of-frame checks, in the fixed error order
    always_comb begin
        o_summary          = '0;
        o_summary.status   = l4tp_pkg::ST_OK;
        o_summary.l3_kind  = l4tp_pkg::L3_OTHER;
        o_summary.l4_kind  = l4tp_pkg::L4_NONE;
        if (n_et == l4tp_pkg::ET_IPV4) begin
            o_summary.l3_kind = l4tp_pkg::L3_IPV4;
        end else if (n_et == l4tp_pkg::ET_IPV6) begin
            o_summary.l3_kind = l4tp_pkg::L3_IPV6;
        end else if (n_et == l4tp_pkg::ET_ARP) begin
            o_summary.l3_kind = l4tp_pkg::L3_ARP;
        end

        if (o_summary.l3_kind != l4tp_pkg::L3_IPV4 && o_summary.l3_kind != l4tp_pkg::L3_IPV6) begin
            o_summary.status = l4tp_pkg::ST_NOT_IP;
        end else if (w_len < {1'b0, l4tp_pkg::ETH_HDR_LEN}) begin
            o_summary.status = l4tp_pkg::ST_SHORT_ETH;
        end else begin
            o_summary.dst_mac = n_dmac;
            o_summary.src_mac = n_smac;
            if (w_len < {1'b0, l4tp_pkg::ETH_HDR_LEN} + 9'd1) begin
                o_summary.status = l4tp_pkg::ST_SHORT_VER;
            end else if (o_summary.l3_kind == l4tp_pkg::L3_IPV6 &&
                         n_ver != l4tp_pkg::VERSION_IPV6) begin
                o_summary.status = l4tp_pkg::ST_V6_MISMATCH;
            end else if (o_summary.l3_kind == l4tp_pkg::L3_IPV4 &&
                         n_ver != l4tp_pkg::VERSION_IPV4) begin
                o_summary.status = l4tp_pkg::ST_V4_MISMATCH;
            end else if (o_summary.l3_kind == l4tp_pkg::L3_IPV4 &&
                         w_len < {1'b0, l4tp_pkg::ETH_HDR_LEN} + l4tp_pkg::IPV4_MIN_LEN) begin
                o_summary.status = l4tp_pkg::ST_SHORT_V4;
            end else begin
                o_summary.hdr_len = n_hl;
                if (w_len < w_l4_start9) begin
                    o_summary.status = (o_summary.l3_kind == l4tp_pkg::L3_IPV4)
                                     ? l4tp_pkg::ST_SHORT_V4_OPT : l4tp_pkg::ST_SHORT_V6;
                end else if (n_proto == l4tp_pkg::PROTO_TCP) begin
                    // short tcp header is not an error, just no l4 info
                    if (w_len >= w_l4_start9 + l4tp_pkg::TCP_MIN_LEN) begin
                        o_summary.l4_kind  = l4tp_pkg::L4_TCP;
                        o_summary.src_port = n_sport;
                        o_summary.dst_port = n_dport;
                    end
                end else if (n_proto == l4tp_pkg::PROTO_UDP) begin
                    if (w_len < w_l4_start9 + l4tp_pkg::UDP_ICMP_LEN) begin
                        o_summary.status = l4tp_pkg::ST_SHORT_UDP;
                    end else begin
                        o_summary.l4_kind  = l4tp_pkg::L4_UDP;
                        o_summary.src_port = n_sport;
                        o_summary.dst_port = n_dport;
                    end
                end else if (n_proto == l4tp_pkg::PROTO_ICMP) begin
                    if (w_len < w_l4_start9 + l4tp_pkg::UDP_ICMP_LEN) begin
                        o_summary.status = l4tp_pkg::ST_SHORT_ICMP;
                    end else begin
                        o_summary.l4_kind = l4tp_pkg::L4_ICMP;
                    end
                end
            end
        end

        if (o_summary.status == l4tp_pkg::ST_OK) begin
            o_summary.last_idx = (o_summary.l3_kind == l4tp_pkg::L3_IPV4)
                               ? l4tp_pkg::WIDX_W'(1) : l4tp_pkg::WIDX_W'(l4tp_pkg::ADDR_WORDS - 1);
            o_words = n_addr;
        end else begin
            o_summary.l4_kind  = l4tp_pkg::L4_NONE;
            o_summary.src_port = '0;
            o_summary.dst_port = '0;
            o_summary.last_idx = '0;
            if (o_summary.status != l4tp_pkg::ST_SHORT_V4_OPT &&
                o_summary.status != l4tp_pkg::ST_SHORT_V6) begin
                o_summary.hdr_len = '0;
            end
            o_words = '0;
        end
    end

    // all capture state returns to zero after each frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last_byte)) begin
            r_off   <= '0;
            r_et    <= '0;
            r_dmac  <= '0;
            r_smac  <= '0;
            r_ver   <= '0;
            r_hl    <= '0;
            r_proto <= '0;
            r_addr  <= '0;
            r_sport <= '0;
            r_dport <= '0;
        end else begin
            r_off   <= n_off;
            r_et    <= n_et;
            r_dmac  <= n_dmac;
            r_smac  <= n_smac;
            r_ver   <= n_ver;
            r_hl    <= n_hl;
            r_proto <= n_proto;
            r_addr  <= n_addr;
            r_sport <= n_sport;
            r_dport <= n_dport;
        end
    end

endmodule

>>> src/eth_ip_l4_tuple_parser.sv
// ----------------------------------------------------------------------------
// eth_ip_l4_tuple_parser: Ethernet / IPv4 / IPv6 / L4 tuple parser
// Captures header fields byte by byte and emits a run of result items at the
// end of each frame: two address words for IPv4, eight for IPv6, one on error.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  input    in         i_valid / o_stall    i_ether_type, i_frame_byte, i_last_byte
//  result   out        o_valid / i_stall    o_status .. o_run_last
//
//  one frame byte is taken every cycle unless o_stall holds off a last byte;
//  the capture registers are updated in the cycle the byte is accepted.
//  a frame's results appear from the cycle after its last byte, one item per
//  cycle while i_stall is low: 1, 2 or 8 items, held in the single result register stage.
//  a last byte is held off only while the previous run still has items to
//  deliver; other bytes are always taken.
//  synchronous active-low reset clears the capture state and the result stage's busy flag and index.
//
module eth_ip_l4_tuple_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_ether_type,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_status,
    output logic [1:0]  o_l3_kind,
    output logic [1:0]  o_l4_kind,
    output logic [5:0]  o_ip_header_len,
    output logic [15:0] o_source_port,
    output logic [15:0] o_destination_port,
    output logic [47:0] o_dest_mac,
    output logic [47:0] o_source_mac,
    output logic [2:0]  o_word_index,
    output logic [31:0] o_address_word,
    output logic        o_run_last
);

    l4tp_pkg::t_summary    w_summary;
    l4tp_pkg::t_addr_words w_words;

    logic                        r_busy;
    logic [l4tp_pkg::WIDX_W-1:0] r_idx;
    l4tp_pkg::t_summary          r_sum;
    l4tp_pkg::t_addr_words       r_words;

    logic w_out_fire;
    logic w_run_done;
    logic w_in_fire;
    logic w_load;

    assign w_out_fire = r_busy && !i_stall;
    assign w_run_done = w_out_fire && o_run_last;
    // only a last byte needs the result stage free
    assign o_stall    = i_last_byte && r_busy && !w_run_done;
    assign w_in_fire  = i_valid && !o_stall;
    assign w_load     = w_in_fire && i_last_byte;

    l4tp_capture u_capture (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_in_fire),
        .i_ether_type (i_ether_type),
        .i_frame_byte (i_frame_byte),
        .i_last_byte  (i_last_byte),
        .o_summary    (w_summary),
        .o_words      (w_words)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (w_load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (w_run_done) begin
            r_busy <= 1'b0;
        end else if (w_out_fire) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_sum   <= w_summary;
            r_words <= w_words;
        end
    end

    assign o_valid            = r_busy;
    assign o_status           = r_sum.status;
    assign o_l3_kind          = r_sum.l3_kind;
    assign o_l4_kind          = r_sum.l4_kind;
    assign o_ip_header_len    = r_sum.hdr_len;
    assign o_source_port      = r_sum.src_port;
    assign o_destination_port = r_sum.dst_port;
    assign o_dest_mac         = r_sum.dst_mac;
    assign o_source_mac       = r_sum.src_mac;
    assign o_word_index       = r_idx;
    assign o_address_word     = r_words[r_idx];
    assign o_run_last         = (r_idx == r_sum.last_idx);

    a_stall_only_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input held off with no run in progress");

    a_run_follows_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_last_byte) |=> o_valid && (o_word_index == 3'd0))
        else $error("last byte accepted but no run started");

    a_ok_run_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_run_last && o_status == l4tp_pkg::ST_OK)
            |-> (o_word_index == 3'd1 || o_word_index == 3'd7))
        else $error("address run ended at a wrong word");

    a_error_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != l4tp_pkg::ST_OK)
            |-> (o_run_last && o_word_index == 3'd0 && o_address_word == 32'd0))
        else $error("error result is not a single item");

endmodule

>>> dv/tb_eth_ip_l4_tuple_parser.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_eth_ip_l4_tuple_parser: self-checking bench for the L2/L3/L4 tuple parser
// Frames are fed one byte per item with random idle gaps on both channels.
// A table of directed frames covers every status code, the header length
// extremes and a long frame. Random frames, mostly well-formed IPv4/IPv6 with
// random contents, follow. Every result item is checked field by field
// against a byte-level predictor of the capture registers and length checks.
// ----------------------------------------------------------------------------
module tb_eth_ip_l4_tuple_parser;

    import l4tp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        t_status     status;
        t_l3_kind    l3;
        t_l4_kind    l4;
        logic [5:0]  hlen;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [47:0] dmac;
        logic [47:0] smac;
        logic [2:0]  widx;
        logic [31:0] aword;
        logic        last;
    } tuple_item_t;

    typedef struct {
        logic [15:0] et;
        int          len;
        logic [3:0]  ver;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        bit          typed;
        t_status     st;
        t_l3_kind    l3;
    } dir_frame_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [15:0] i_ether_type = '0;
    logic [7:0]  i_frame_byte = '0;
    logic        i_last_byte = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [3:0]  o_status;
    logic [1:0]  o_l3_kind;
    logic [1:0]  o_l4_kind;
    logic [5:0]  o_ip_header_len;
    logic [15:0] o_source_port;
    logic [15:0] o_destination_port;
    logic [47:0] o_dest_mac;
    logic [47:0] o_source_mac;
    logic [2:0]  o_word_index;
    logic [31:0] o_address_word;
    logic        o_run_last;

    // predictor copy of the capture state
    logic [7:0]  p_off = '0;
    logic [15:0] p_etype = '0;
    logic [47:0] p_mac [2] = '{default: '0};
    logic [3:0]  p_ver = '0;
    logic [5:0]  p_hlen = '0;
    logic [7:0]  p_proto = '0;
    logic [31:0] p_addr [8] = '{default: '0};
    logic [15:0] p_port [2] = '{default: '0};

    tuple_item_t expected_tuples [$];
    tuple_item_t frame_run [$];
    logic [7:0]  frame_bytes [0:511];

    int  mismatches = 0;
    int  cycle_count = 0;
    int  results_made = 0;
    int  rand_bytes = 0;
    int  stall_run = 0;
    bit  quiet_tail = 1'b0;

    dir_frame_t dir_tab [22] = '{
        '{ET_ARP,   1,   4'd0, 4'd0,  8'd0,       1'b1, ST_NOT_IP,    L3_ARP},
        '{16'hFFFF, 20,  4'd0, 4'd0,  8'd0,       1'b1, ST_NOT_IP,    L3_OTHER},
        '{16'h0000, 3,   4'd0, 4'd0,  8'd0,       1'b1, ST_NOT_IP,    L3_OTHER},
        '{ET_IPV4,  13,  4'd0, 4'd0,  8'd0,       1'b1, ST_SHORT_ETH, L3_IPV4},
        '{ET_IPV6,  1,   4'd0, 4'd0,  8'd0,       1'b1, ST_SHORT_ETH, L3_IPV6},
        '{ET_IPV4,  14,  4'd4, 4'd5,  PROTO_TCP,  1'b0, ST_OK,        L3_OTHER},
        '{ET_IPV6,  15,  4'd4, 4'd0,  PROTO_TCP,  1'b0, ST_OK,        L3_OTHER},
        '{ET_IPV4,  40,  4'd6, 4'd5,  PROTO_TCP,  1'b0, ST_OK,        L3_OTHER},
        '{ET_IPV4,  20,  4'd0, 4'd15, PROTO_UDP,  1'b0, ST_OK,        L3_OTHER},
        '{ET_IPV4,  33,  4'd4, 4'd5,  PROTO_TCP,  1'b0, ST_OK,        L3_OTHER},
        '{ET_IPV4,  73,  4'd4, 4'd15, PROTO_TCP,  1'b0, ST_OK,        L3_OTHER},
        '{ET_IPV6,  53,  4'd6, 4'd15, PROTO_UDP,  1'b0, ST_OK,        L3_OTHER},
        '{ET_IPV4,  41,  4'd4, 4'd5,  PROTO_UDP,  1'b0, ST_OK,        L3_OTHER},
        '{ET_IPV6,  61,  4'd6, 4'd0,  PROTO_ICMP, 1'b0, ST_OK,        L3_OTHER},
        '{ET_IPV4,  53,  4'd4, 4'd5,  PROTO_TCP,  1'b0, ST_OK,        L3_OTHER},
        '{ET_IPV4,  94,  4'd4, 4'd15, PROTO_TCP,  1'b0, ST_OK,        L3_OTHER},
        '{ET_IPV6,  62,  4'd6, 4'd3,  PROTO_UDP,  1'b0, ST_OK,        L3_OTHER},
        '{ET_IPV4,  40,  4'd4, 4'd0,  PROTO_UDP,  1'b0, ST_OK,        L3_OTHER},
        '{ET_IPV4,  60,  4'd4, 4'd2,  PROTO_TCP,  1'b0, ST_OK,        L3_OTHER},
        '{ET_IPV6,  300, 4'd6, 4'd9,  PROTO_ICMP, 1'b0, ST_OK,        L3_OTHER},
        '{ET_IPV4,  34,  4'd4, 4'd5,  8'hFF,      1'b0, ST_OK,        L3_OTHER},
        '{ET_IPV4,  50,  4'd4, 4'd6,  PROTO_ICMP, 1'b0, ST_OK,        L3_OTHER}
    };

    eth_ip_l4_tuple_parser uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_ether_type       (i_ether_type),
        .i_frame_byte       (i_frame_byte),
        .i_last_byte        (i_last_byte),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_status           (o_status),
        .o_l3_kind          (o_l3_kind),
        .o_l4_kind          (o_l4_kind),
        .o_ip_header_len    (o_ip_header_len),
        .o_source_port      (o_source_port),
        .o_destination_port (o_destination_port),
        .o_dest_mac         (o_dest_mac),
        .o_source_mac       (o_source_mac),
        .o_word_index       (o_word_index),
        .o_address_word     (o_address_word),
        .o_run_last         (o_run_last)
    );

    always #1 i_clk = ~i_clk;

    // byte-level predictor: updates captures, fills frame_run on the last byte
    function automatic void parse_byte(logic [15:0] et_in, logic [7:0] b, logic last);
        int          off, len, l4start, rel, idx, n;
        t_status     st;
        t_l3_kind    l3;
        t_l4_kind    l4;
        logic [5:0]  hl;
        logic [15:0] sp, dp;
        logic [47:0] dm, sm;
        tuple_item_t r;
        off = int'(p_off);
        st = ST_OK;
        l4 = L4_NONE;
        hl = '0;
        sp = '0;
        dp = '0;
        dm = '0;
        sm = '0;
        if (off == 0) p_etype = et_in;
        if (off < int'(OFF_SRC_MAC)) p_mac[0] = {p_mac[0][39:0], b};
        else if (off < int'(OFF_MAC_END)) p_mac[1] = {p_mac[1][39:0], b};
        if (off == int'(ETH_HDR_LEN)) begin
            p_ver = b[7:4];
            p_hlen = (p_etype == ET_IPV6) ? IPV6_HDR_LEN : {b[3:0], 2'b00};
        end
        if (p_etype == ET_IPV4) begin
            if (off == int'(OFF_V4_PROTO)) p_proto = b;
            if (off >= int'(OFF_V4_ADDR) && off < int'(END_V4_ADDR)) begin
                idx = (off - int'(OFF_V4_ADDR)) >> 2;
                p_addr[idx] = {p_addr[idx][23:0], b};
            end
        end else if (p_etype == ET_IPV6) begin
            if (off == int'(OFF_V6_NXT)) p_proto = b;
            if (off >= int'(OFF_V6_ADDR) && off < int'(END_V6_ADDR)) begin
                idx = (off - int'(OFF_V6_ADDR)) >> 2;
                p_addr[idx] = {p_addr[idx][23:0], b};
            end
        end
        // l4 ports sit right after the ip header, at the length the ihl gives, even a short one
        if (off >= int'(ETH_HDR_LEN) + int'(p_hlen)) begin
            rel = off - int'(ETH_HDR_LEN) - int'(p_hlen);
            if (rel < 2) p_port[0] = {p_port[0][7:0], b};
            else if (rel < 4) p_port[1] = {p_port[1][7:0], b};
        end
        if (!last) begin
            if (p_off != OFF_MAX) p_off = p_off + 8'd1;
            return;
        end

        len = off + 1;
        l3 = (p_etype == ET_IPV4) ? L3_IPV4 : (p_etype == ET_IPV6) ? L3_IPV6 :
             (p_etype == ET_ARP) ? L3_ARP : L3_OTHER;
        if (l3 != L3_IPV4 && l3 != L3_IPV6) begin
            st = ST_NOT_IP;
        end else if (len < int'(ETH_HDR_LEN)) begin
            st = ST_SHORT_ETH;
        end else begin
            dm = p_mac[0];
            sm = p_mac[1];
            l4start = int'(ETH_HDR_LEN) + int'(p_hlen);
            if (len < int'(ETH_HDR_LEN) + 1) begin
                st = ST_SHORT_VER;
            end else if (l3 == L3_IPV6 && p_ver != VERSION_IPV6) begin
                st = ST_V6_MISMATCH;
            end else if (l3 == L3_IPV4 && p_ver != VERSION_IPV4) begin
                st = ST_V4_MISMATCH;
            end else if (l3 == L3_IPV4 && len < int'(ETH_HDR_LEN) + int'(IPV4_MIN_LEN)) begin
                st = ST_SHORT_V4;
            end else begin
                hl = p_hlen;
                if (len < l4start) begin
                    st = (l3 == L3_IPV4) ? ST_SHORT_V4_OPT : ST_SHORT_V6;
                end else if (p_proto == PROTO_TCP) begin
                    // a short tcp header is not an error, just no ports
                    if (len >= l4start + int'(TCP_MIN_LEN)) begin
                        l4 = L4_TCP;
                        sp = p_port[0];
                        dp = p_port[1];
                    end
                end else if (p_proto == PROTO_UDP) begin
                    if (len < l4start + int'(UDP_ICMP_LEN)) begin
                        st = ST_SHORT_UDP;
                    end else begin
                        l4 = L4_UDP;
                        sp = p_port[0];
                        dp = p_port[1];
                    end
                end else if (p_proto == PROTO_ICMP) begin
                    if (len < l4start + int'(UDP_ICMP_LEN)) st = ST_SHORT_ICMP;
                    else l4 = L4_ICMP;
                end
            end
        end

        if (st != ST_OK) begin
            r = '0;
            r.status = st;
            r.l3 = l3;
            r.dmac = dm;
            r.smac = sm;
            r.hlen = (st == ST_SHORT_V4_OPT || st == ST_SHORT_V6) ? hl : 6'd0;
            r.last = 1'b1;
            frame_run.push_back(r);
        end else begin
            n = (l3 == L3_IPV4) ? 2 : 8;
            for (int i = 0; i < n; i++) begin
                r.status = ST_OK;
                r.l3 = l3;
                r.l4 = l4;
                r.hlen = hl;
                r.sport = sp;
                r.dport = dp;
                r.dmac = dm;
                r.smac = sm;
                r.widx = 3'(i);
                r.aword = p_addr[i];
                r.last = (i == n - 1);
                frame_run.push_back(r);
            end
        end

        // capture state clears after every frame
        p_off = '0;
        p_etype = '0;
        p_mac = '{default: '0};
        p_ver = '0;
        p_hlen = '0;
        p_proto = '0;
        p_addr = '{default: '0};
        p_port = '{default: '0};
    endfunction

    task automatic send_frame(logic [15:0] et, int len, logic [3:0] ver, logic [3:0] ihl,
                              logic [7:0] proto, bit typed, t_status tst, t_l3_kind tl3);
        tuple_item_t want;
        int          gap;
        for (int i = 0; i < len; i++) frame_bytes[i] = 8'($urandom_range(0, 255));
        if (len > int'(ETH_HDR_LEN)) frame_bytes[ETH_HDR_LEN] = {ver, ihl};
        if (et == ET_IPV4 && len > int'(OFF_V4_PROTO)) frame_bytes[OFF_V4_PROTO] = proto;
        if (et == ET_IPV6 && len > int'(OFF_V6_NXT)) frame_bytes[OFF_V6_NXT] = proto;
        for (int i = 0; i < len; i++) begin
            if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                i_valid <= 1'b0;
                gap = $urandom_range(1, 15);
                repeat (gap) @(negedge i_clk);
            end
            i_valid <= 1'b1;
            // ethertype only matters on the first byte, so the rest get noise
            i_ether_type <= (i == 0) ? et : 16'($urandom_range(0, 65535));
            i_frame_byte <= frame_bytes[i];
            i_last_byte <= (i == len - 1);
            do @(posedge i_clk); while (o_stall);
            frame_run.delete();
            parse_byte(i_ether_type, i_frame_byte, i_last_byte);
            if (i == len - 1) begin
                if (typed) begin
                    want = '0;
                    want.status = tst;
                    want.l3 = tl3;
                    want.last = 1'b1;
                    expected_tuples.push_back(want);
                    results_made++;
                end else begin
                    foreach (frame_run[k]) expected_tuples.push_back(frame_run[k]);
                    results_made += frame_run.size();
                end
            end
            @(negedge i_clk);
        end
    endtask

    task automatic send_random_frame();
        int          pick, hl, l4start, len;
        logic [15:0] et;
        logic [3:0]  ver, ihl;
        logic [7:0]  proto;
        pick = $urandom_range(0, 99);
        ihl = ($urandom_range(0, 9) < 7) ? 4'd5 : 4'($urandom_range(0, 15));
        case ($urandom_range(0, 3))
            0:       proto = PROTO_TCP;
            1:       proto = PROTO_UDP;
            2:       proto = PROTO_ICMP;
            default: proto = 8'($urandom_range(0, 255));
        endcase
        if (pick < 10) begin
            et = (pick < 4) ? ET_ARP : 16'($urandom_range(0, 65535));
            ver = 4'($urandom_range(0, 15));
            len = $urandom_range(1, 80);
        end else begin
            et = ($urandom_range(0, 1) == 1) ? ET_IPV6 : ET_IPV4;
            ver = (et == ET_IPV6) ? VERSION_IPV6 : VERSION_IPV4;
            hl = (et == ET_IPV6) ? int'(IPV6_HDR_LEN) : int'(ihl) * 4;
            l4start = int'(ETH_HDR_LEN) + hl;
            if (pick < 22) begin
                // truncated or mislabelled frames
                len = $urandom_range(1, l4start + 24);
                if ($urandom_range(0, 2) == 0) ver = 4'($urandom_range(0, 15));
            end else begin
                len = ((l4start > 34) ? l4start : 34) + 20 + $urandom_range(0, 30);
                if ($urandom_range(0, 29) == 0) len = $urandom_range(256, 320);
            end
        end
        send_frame(et, len, ver, ihl, proto, 1'b0, ST_OK, L3_OTHER);
        rand_bytes += len;
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (expected_tuples.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic check_field(string fname, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
            mismatches++;
        end
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n || quiet_tail) begin
            i_stall <= 1'b0;
        end else if (stall_run > 0) begin
            i_stall <= 1'b1;
            stall_run--;
        end else if ($urandom_range(0, 7) == 0) begin
            i_stall <= 1'b1;
            stall_run = $urandom_range(1, 15) - 1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        tuple_item_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_tuples.size() == 0) begin
                $display("%0t: unexpected result item, expected none, actual status %0d index %0d",
                         $time, o_status, o_word_index);
                mismatches++;
            end else begin
                want = expected_tuples.pop_front();
                check_field("status", want.status, o_status);
                check_field("l3_kind", want.l3, o_l3_kind);
                check_field("l4_kind", want.l4, o_l4_kind);
                check_field("ip_header_len", want.hlen, o_ip_header_len);
                check_field("source_port", want.sport, o_source_port);
                check_field("destination_port", want.dport, o_destination_port);
                check_field("dest_mac", want.dmac, o_dest_mac);
                check_field("source_mac", want.smac, o_source_mac);
                check_field("word_index", want.widx, o_word_index);
                check_field("address_word", want.aword, o_address_word);
                check_field("run_last", want.last, o_run_last);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_eth_ip_l4_tuple_parser failed");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_tab[r]) begin
            send_frame(dir_tab[r].et, dir_tab[r].len, dir_tab[r].ver, dir_tab[r].ihl,
                       dir_tab[r].proto, dir_tab[r].typed, dir_tab[r].st, dir_tab[r].l3);
        end
        wait_for_results();

        results_made = 0;
        while (rand_bytes < 210 || results_made < 48) begin
            send_random_frame();
            if ($urandom_range(0, 11) == 0) wait_for_results();
        end

        // back-to-back tail with no gaps on either side
        quiet_tail = 1'b1;
        repeat (3) send_random_frame();
        wait_for_results();
        repeat (20) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("tb_eth_ip_l4_tuple_parser passed");
        end else begin
            $display("tb_eth_ip_l4_tuple_parser failed");
        end
        $finish;
    end

endmodule

>>> files.f
src/l4tp_pkg.sv
src/l4tp_capture.sv
src/eth_ip_l4_tuple_parser.sv
dv/tb_eth_ip_l4_tuple_parser.sv
